// File: src/tcvi_pkg.sv
// Shared types, constants and helpers of the tilt-compensated velocity integrator.
package tcvi_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [2:0] REG_OFFSET_X      = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y      = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z      = 3'd2;
  localparam logic [2:0] REG_FILTER_GAIN   = 3'd3;
  localparam logic [2:0] REG_DEAD_BAND     = 3'd4;
  localparam logic [2:0] REG_LEAK_FACTOR   = 3'd5;
  localparam logic [2:0] REG_GRAVITY_SCALE = 3'd6;

  localparam logic [1:0] ANG_SP = 2'd0;
  localparam logic [1:0] ANG_CP = 2'd1;
  localparam logic [1:0] ANG_SR = 2'd2;
  localparam logic [1:0] ANG_CR = 2'd3;

  localparam logic [16:0] GAIN_ONE      = 17'd65536;
  localparam logic [30:0] Q30_ONE       = 31'd1073741824;
  localparam logic [32:0] RECIP_72      = 33'd7635497416;
  localparam logic [32:0] RECIP_42      = 33'd6544712071;
  localparam logic [32:0] RECIP_20      = 33'd6871947674;
  localparam logic [32:0] RECIP_6       = 33'd5726623062;
  localparam logic [46:0] DIV_BASE      = 47'd15625;
  localparam logic [32:0] RECIP_15625   = 33'd4503599627;
  localparam logic [5:0]  DIV_STEPS     = 6'd7;

  typedef struct packed {
    logic [13:0] arg;
    logic        neg;
  } ang_t;

  typedef struct packed {
    ang_t [3:0]         ang;
    logic signed [16:0] bx;
    logic signed [16:0] by;
    logic signed [16:0] bz;
    logic [19:0]        dt;
  } item_t;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic [16:0]        filter_gain;
    logic [19:0]        dead_band;
    logic [16:0]        leak_factor;
    logic [19:0]        gravity_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        speed_out;
    logic signed [31:0] acc_x_filtered;
    logic signed [31:0] acc_y_filtered;
    logic signed [31:0] acc_z_filtered;
  } result_t;

  // round by 16 bits to nearest, then saturate to 32 bits
  function automatic logic signed [31:0] rnd_sat16(input logic signed [69:0] v);
    logic signed [69:0] t;
    t = (v + 70'sd32768) >>> 16;
    if (t > 70'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (t < -70'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(t);
  endfunction

endpackage

// File: src/tcvi_front.sv
// Front end: offset removal and quadrant folding of the four trig angles.
module tcvi_front
  import tcvi_pkg::*;
(
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic [19:0]        interval_us_i,
  input  cfg_t               cfg_i,
  output item_t              item_o
);

  function automatic ang_t fold(input logic signed [16:0] a);
    logic signed [17:0] m;
    logic [15:0]        mu;
    ang_t               r;
    m = 18'(a);
    if (m < 18'sd0) begin
      m = m + 18'sd36000;
    end else if (m >= 18'sd36000) begin
      m = m - 18'sd36000;
    end
    mu = m[15:0];
    if (mu < 16'd9000) begin
      r.arg = 14'(mu);
      r.neg = 1'b0;
    end else if (mu < 16'd18000) begin
      r.arg = 14'(16'd18000 - mu);
      r.neg = 1'b0;
    end else if (mu < 16'd27000) begin
      r.arg = 14'(mu - 16'd18000);
      r.neg = 1'b1;
    end else begin
      r.arg = 14'(16'd36000 - mu);
      r.neg = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    item_o.ang[ANG_SP] = fold(17'(pitch_angle_i));
    item_o.ang[ANG_CP] = fold(17'(pitch_angle_i) + 17'sd9000);
    item_o.ang[ANG_SR] = fold(17'(roll_angle_i));
    item_o.ang[ANG_CR] = fold(17'(roll_angle_i) + 17'sd9000);
    item_o.bx = 17'(accel_x_i) - 17'(cfg_i.offset_x);
    item_o.by = 17'(accel_y_i) - 17'(cfg_i.offset_y);
    item_o.bz = 17'(accel_z_i) - 17'(cfg_i.offset_z);
    item_o.dt = interval_us_i;
  end

endmodule

// File: src/tcvi_queue.sv
// Two-entry item queue between front end and back end.
module tcvi_queue
  import tcvi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = do_push ? wp_q + 1'b1 : wp_q;
    rp_d  = do_pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= item_i;
    end
  end

endmodule

// File: src/tcvi_back.sv
// Back end: sequencer over one shared multiplier, quotient and square root units.
module tcvi_back
  import tcvi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  input  cfg_t    cfg_i,
  input  logic    res_pop_i,
  output logic    res_valid_o,
  output result_t res_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SIN  = 8'b0000_0010,
    ST_ROT  = 8'b0000_0100,
    ST_AXIS = 8'b0000_1000,
    ST_DIV  = 8'b0001_0000,
    ST_VEL  = 8'b0010_0000,
    ST_SQRT = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  localparam logic [3:0] SIN_X   = 4'd0;
  localparam logic [3:0] SIN_X2  = 4'd1;
  localparam logic [3:0] SIN_D72 = 4'd2;
  localparam logic [3:0] SIN_H1  = 4'd3;
  localparam logic [3:0] SIN_D42 = 4'd4;
  localparam logic [3:0] SIN_H2  = 4'd5;
  localparam logic [3:0] SIN_D20 = 4'd6;
  localparam logic [3:0] SIN_H3  = 4'd7;
  localparam logic [3:0] SIN_D6  = 4'd8;
  localparam logic [3:0] SIN_S   = 4'd9;

  localparam logic [3:0] ROT_SS  = 4'd0;
  localparam logic [3:0] ROT_CS  = 4'd1;
  localparam logic [3:0] ROT_SC  = 4'd2;
  localparam logic [3:0] ROT_CC  = 4'd3;
  localparam logic [3:0] ROT_X0  = 4'd4;
  localparam logic [3:0] ROT_X1  = 4'd5;
  localparam logic [3:0] ROT_X2  = 4'd6;
  localparam logic [3:0] ROT_Y0  = 4'd7;
  localparam logic [3:0] ROT_Y1  = 4'd8;
  localparam logic [3:0] ROT_Z0  = 4'd9;
  localparam logic [3:0] ROT_Z1  = 4'd10;
  localparam logic [3:0] ROT_Z2  = 4'd11;

  localparam logic [3:0] AX_NET  = 4'd0;
  localparam logic [3:0] AX_NEW  = 4'd1;
  localparam logic [3:0] AX_OLD  = 4'd2;
  localparam logic [3:0] AX_P    = 4'd3;

  localparam logic [3:0] VL_LEAK = 4'd0;
  localparam logic [3:0] VL_SQ   = 4'd1;

  state_e             state_q, state_d;
  logic [3:0]         op_q, op_d;
  logic [1:0]         idx_q, idx_d;
  logic               ph_q, ph_d;
  logic [5:0]         cnt_q, cnt_d;
  logic               ov_q, ov_d;
  logic               load_out, mul_st, last_op, consume;

  item_t              it_q;
  logic signed [69:0] prod_q;
  logic signed [34:0] mul_a, mul_b;
  logic [30:0]        x_q, t_q;
  logic [31:0]        x2_q, v_q;
  logic signed [15:0] sn_q [4];
  logic signed [29:0] ss_q, cs_q, sc_q, cc_q;
  logic signed [47:0] e_q [3];
  logic signed [31:0] net_q;
  logic signed [51:0] acc_q;
  logic signed [31:0] fnew_q [3];
  logic signed [53:0] p_q [3];
  logic signed [33:0] inc_q [3];
  logic signed [31:0] fa_q [3];
  logic signed [31:0] vel_q [3];
  logic [46:0]        rem_q;
  logic [64:0]        dprod_q;
  logic [32:0]        quo_q;
  logic [63:0]        sq_q, res_q, bit_q;
  result_t            out_q;

  logic [16:0]        gain_c, leak_c;
  logic [31:0]        s_full;
  logic [16:0]        s_rnd;
  logic [14:0]        s_cl;
  logic signed [15:0] sin_val;
  logic signed [47:0] g_t;
  logic signed [31:0] f_raw, f_dz;
  logic signed [32:0] f_w, f_mag;
  logic [53:0]        p_abs;
  logic [54:0]        p_bias;
  logic               ge;
  logic [32:0]        quo_n;
  logic signed [33:0] inc_val;
  logic [63:0]        trial;

  assign gain_c = (cfg_i.filter_gain > GAIN_ONE) ? GAIN_ONE : cfg_i.filter_gain;
  assign leak_c = (cfg_i.leak_factor > GAIN_ONE) ? GAIN_ONE : cfg_i.leak_factor;

  assign mul_st  = (state_q == ST_SIN) || (state_q == ST_ROT) ||
                   (state_q == ST_AXIS) || (state_q == ST_VEL);
  assign consume = mul_st && ph_q;

  always_comb begin
    s_full  = 32'(prod_q >>> 30);
    s_rnd   = 17'((33'(s_full) + 33'd32768) >> 16);
    s_cl    = (s_rnd > 17'd16384) ? 15'd16384 : 15'(s_rnd);
    sin_val = it_q.ang[idx_q].neg ? -signed'({1'b0, s_cl}) : signed'({1'b0, s_cl});
    g_t     = e_q[idx_q] + 48'sd8388608;
    f_raw   = rnd_sat16(70'(acc_q) + prod_q);
    f_w     = 33'(f_raw);
    f_mag   = (f_w < 33'sd0) ? -f_w : f_w;
    f_dz    = (f_mag < signed'({13'b0, cfg_i.dead_band})) ? 32'sd0 : f_raw;
    p_abs   = p_q[idx_q][53] ? 54'(~p_q[idx_q] + 54'd1) : 54'(p_q[idx_q]);
    p_bias  = 55'(p_abs) + 55'd1000000;
    ge      = (rem_q >= DIV_BASE);
    quo_n   = quo_q + 33'(ge);
    inc_val = p_q[idx_q][53] ? -signed'({1'b0, quo_n}) : signed'({1'b0, quo_n});
    trial   = res_q + bit_q;
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SIN: begin
        unique case (op_q)
          SIN_X:   begin mul_a = signed'({21'b0, it_q.ang[idx_q].arg}); mul_b = 35'sd187403; end
          SIN_X2:  begin mul_a = signed'({4'b0, x_q}); mul_b = signed'({4'b0, x_q}); end
          SIN_D72: begin mul_a = signed'({3'b0, x2_q}); mul_b = signed'({2'b0, RECIP_72}); end
          SIN_D42: begin mul_a = signed'({3'b0, v_q}); mul_b = signed'({2'b0, RECIP_42}); end
          SIN_D20: begin mul_a = signed'({3'b0, v_q}); mul_b = signed'({2'b0, RECIP_20}); end
          SIN_D6:  begin mul_a = signed'({3'b0, v_q}); mul_b = signed'({2'b0, RECIP_6}); end
          SIN_S:   begin mul_a = signed'({4'b0, x_q}); mul_b = signed'({4'b0, t_q}); end
          default: begin mul_a = signed'({3'b0, x2_q}); mul_b = signed'({4'b0, t_q}); end
        endcase
      end
      ST_ROT: begin
        unique case (op_q)
          ROT_SS:  begin mul_a = 35'(sn_q[ANG_SR]); mul_b = 35'(sn_q[ANG_SP]); end
          ROT_CS:  begin mul_a = 35'(sn_q[ANG_CR]); mul_b = 35'(sn_q[ANG_SP]); end
          ROT_SC:  begin mul_a = 35'(sn_q[ANG_SR]); mul_b = 35'(sn_q[ANG_CP]); end
          ROT_CC:  begin mul_a = 35'(sn_q[ANG_CR]); mul_b = 35'(sn_q[ANG_CP]); end
          ROT_X0:  begin mul_a = 35'(it_q.bx); mul_b = 35'(sn_q[ANG_CP]); end
          ROT_X1:  begin mul_a = 35'(it_q.by); mul_b = 35'(ss_q); end
          ROT_X2:  begin mul_a = 35'(it_q.bz); mul_b = 35'(cs_q); end
          ROT_Y0:  begin mul_a = 35'(it_q.by); mul_b = 35'(sn_q[ANG_CR]); end
          ROT_Y1:  begin mul_a = 35'(it_q.bz); mul_b = 35'(sn_q[ANG_SR]); end
          ROT_Z0:  begin mul_a = 35'(it_q.bx); mul_b = 35'(sn_q[ANG_SP]); end
          ROT_Z1:  begin mul_a = 35'(it_q.by); mul_b = 35'(sc_q); end
          default: begin mul_a = 35'(it_q.bz); mul_b = 35'(cc_q); end
        endcase
      end
      ST_AXIS: begin
        unique case (op_q)
          AX_NET: begin
            mul_a = 35'(g_t >>> 24);
            mul_b = signed'({15'b0, cfg_i.gravity_scale});
          end
          AX_NEW: begin mul_a = 35'(net_q); mul_b = signed'({18'b0, gain_c}); end
          AX_OLD: begin
            mul_a = 35'(fa_q[idx_q]);
            mul_b = signed'({18'b0, 17'(GAIN_ONE - gain_c)});
          end
          default: begin
            mul_a = 35'(fa_q[idx_q]) + 35'(fnew_q[idx_q]);
            mul_b = signed'({15'b0, it_q.dt});
          end
        endcase
      end
      ST_VEL: begin
        unique case (op_q)
          VL_LEAK: begin
            mul_a = 35'(vel_q[idx_q]) + 35'(inc_q[idx_q]);
            mul_b = signed'({18'b0, leak_c});
          end
          default: begin mul_a = 35'(vel_q[idx_q]); mul_b = 35'(vel_q[idx_q]); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (state_q)
      ST_SIN:  last_op = (op_q == SIN_S);
      ST_ROT:  last_op = (op_q == ROT_Z2);
      ST_AXIS: last_op = (op_q == AX_P);
      ST_VEL:  last_op = (op_q == VL_SQ);
      default: last_op = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    idx_d      = idx_q;
    ph_d       = ph_q;
    cnt_d      = cnt_q;
    item_pop_o = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          state_d    = ST_SIN;
          op_d       = '0;
          idx_d      = '0;
          ph_d       = 1'b0;
        end
      end
      ST_SIN, ST_ROT, ST_AXIS, ST_VEL: begin
        ph_d = !ph_q;
        if (ph_q) begin
          if (!last_op) begin
            op_d = op_q + 4'd1;
          end else begin
            op_d = '0;
            unique case (state_q)
              ST_SIN: begin
                if (idx_q == ANG_CR) begin
                  state_d = ST_ROT;
                  idx_d   = '0;
                end else begin
                  idx_d = idx_q + 2'd1;
                end
              end
              ST_ROT: begin
                state_d = ST_AXIS;
                idx_d   = '0;
              end
              ST_AXIS: begin
                if (idx_q == 2'd2) begin
                  state_d = ST_DIV;
                  idx_d   = '0;
                  cnt_d   = '0;
                end else begin
                  idx_d = idx_q + 2'd1;
                end
              end
              default: begin
                if (idx_q == 2'd2) begin
                  state_d = ST_SQRT;
                  idx_d   = '0;
                end else begin
                  idx_d = idx_q + 2'd1;
                end
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        if (cnt_q == DIV_STEPS) begin
          cnt_d = '0;
          if (idx_q == 2'd2) begin
            state_d = ST_VEL;
            idx_d   = '0;
            op_d    = '0;
            ph_d    = 1'b0;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_SQRT: begin
        if (bit_q[0]) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_q || res_pop_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    ov_d = load_out ? 1'b1 : (res_pop_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= '0;
      idx_q   <= '0;
      ph_q    <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        fa_q[i]  <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (consume && (state_q == ST_VEL) && (op_q == VL_LEAK)) begin
        vel_q[idx_q] <= rnd_sat16(prod_q);
      end
      if (load_out) begin
        for (int i = 0; i < 3; i++) begin
          fa_q[i] <= fnew_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && item_valid_i) begin
      it_q <= item_i;
      sq_q <= '0;
    end
    if (mul_st && !ph_q) begin
      prod_q <= mul_a * mul_b;
    end
    if (consume) begin
      unique case (state_q)
        ST_SIN: begin
          unique case (op_q)
            SIN_X:   x_q  <= prod_q[30:0];
            SIN_X2:  x2_q <= prod_q[61:30];
            SIN_D72: t_q  <= Q30_ONE - 31'(prod_q >>> 39);
            SIN_D42: t_q  <= Q30_ONE - 31'(prod_q >>> 38);
            SIN_D20: t_q  <= Q30_ONE - 31'(prod_q >>> 37);
            SIN_D6:  t_q  <= Q30_ONE - 31'(prod_q >>> 35);
            SIN_S:   sn_q[idx_q] <= sin_val;
            default: v_q  <= 32'(prod_q >>> 30);
          endcase
        end
        ST_ROT: begin
          unique case (op_q)
            ROT_SS:  ss_q   <= 30'(prod_q);
            ROT_CS:  cs_q   <= 30'(prod_q);
            ROT_SC:  sc_q   <= 30'(prod_q);
            ROT_CC:  cc_q   <= 30'(prod_q);
            ROT_X0:  e_q[0] <= 48'(prod_q) <<< 14;
            ROT_X1:  e_q[0] <= e_q[0] + 48'(prod_q);
            ROT_X2:  e_q[0] <= e_q[0] + 48'(prod_q);
            ROT_Y0:  e_q[1] <= 48'(prod_q) <<< 14;
            ROT_Y1:  e_q[1] <= e_q[1] - (48'(prod_q) <<< 14);
            ROT_Z0:  e_q[2] <= -(48'(prod_q) <<< 14) - 48'sd1099511627776;
            ROT_Z1:  e_q[2] <= e_q[2] + 48'(prod_q);
            default: e_q[2] <= e_q[2] + 48'(prod_q);
          endcase
        end
        ST_AXIS: begin
          unique case (op_q)
            AX_NET:  net_q         <= rnd_sat16(prod_q);
            AX_NEW:  acc_q         <= 52'(prod_q);
            AX_OLD:  fnew_q[idx_q] <= f_dz;
            default: p_q[idx_q]    <= 54'(prod_q);
          endcase
        end
        default: begin
          if (op_q == VL_SQ) begin
            sq_q  <= sq_q + 64'(prod_q);
            res_q <= '0;
            bit_q <= 64'd1 << 62;
          end
        end
      endcase
    end
    // quotient by 15625: reciprocal estimate, back multiply, then correct upward
    if (state_q == ST_DIV) begin
      if (cnt_q == 6'd0) begin
        rem_q <= 47'(p_bias >> 7);
      end else if (cnt_q == 6'd1) begin
        dprod_q <= {33'b0, rem_q[45:14]} * {32'b0, RECIP_15625};
      end else if (cnt_q == 6'd2) begin
        quo_q <= dprod_q[64:32];
      end else if (cnt_q == 6'd3) begin
        rem_q <= rem_q - 47'(quo_q) * DIV_BASE;
      end else begin
        if (ge) begin
          rem_q <= rem_q - DIV_BASE;
        end
        quo_q <= quo_n;
        if (cnt_q == DIV_STEPS) begin
          inc_q[idx_q] <= inc_val;
        end
      end
    end
    if (state_q == ST_SQRT) begin
      if (sq_q >= trial) begin
        sq_q  <= sq_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (load_out) begin
      out_q.vel_x          <= vel_q[0];
      out_q.vel_y          <= vel_q[1];
      out_q.vel_z          <= vel_q[2];
      out_q.speed_out      <= (res_q[63:31] != '0) ? 31'h7FFFFFFF : res_q[30:0];
      out_q.acc_x_filtered <= fnew_q[0];
      out_q.acc_y_filtered <= fnew_q[1];
      out_q.acc_z_filtered <= fnew_q[2];
    end
  end

  assign res_valid_o = ov_q;
  assign res_o       = out_q;

endmodule

// File: src/tilt_compensated_velocity_integrator.sv
// Top level of the tilt-compensated velocity integrator.
// Each IMU sample is worked in the back end as 70 products on one shared
// multiplier (sine and cosine series, frame rotation, filter, trapezoid and
// leak), a quotient by two million per axis (reciprocal estimate, back
// multiply and up to four correction steps), and a square root for the
// speed. A two-entry queue takes new samples while one is in work, and a
// finished result waits in an output register while the next sample runs.
// Registers are to be written only while idle; the block itself does not enforce it.
module tilt_compensated_velocity_integrator
  import tcvi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic [19:0]        interval_us_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o,
  output logic [30:0]        speed_out_o,
  output logic signed [31:0] acc_x_filtered_o,
  output logic signed [31:0] acc_y_filtered_o,
  output logic signed [31:0] acc_z_filtered_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i
);

  cfg_t    cfg_q;
  item_t   front_item, q_item;
  logic    q_valid, q_pop, res_valid;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x      <= '0;
      cfg_q.offset_y      <= '0;
      cfg_q.offset_z      <= '0;
      cfg_q.filter_gain   <= 17'd13107;
      cfg_q.dead_band     <= 20'd3277;
      cfg_q.leak_factor   <= 17'd64880;
      cfg_q.gravity_scale <= 20'd642689;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OFFSET_X:      cfg_q.offset_x      <= cfg_data_i[15:0];
        REG_OFFSET_Y:      cfg_q.offset_y      <= cfg_data_i[15:0];
        REG_OFFSET_Z:      cfg_q.offset_z      <= cfg_data_i[15:0];
        REG_FILTER_GAIN:   cfg_q.filter_gain   <= cfg_data_i[16:0];
        REG_DEAD_BAND:     cfg_q.dead_band     <= cfg_data_i;
        REG_LEAK_FACTOR:   cfg_q.leak_factor   <= cfg_data_i[16:0];
        REG_GRAVITY_SCALE: cfg_q.gravity_scale <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcvi_front u_front (
    .roll_angle_i  (roll_angle_i),
    .pitch_angle_i (pitch_angle_i),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .interval_us_i (interval_us_i),
    .cfg_i         (cfg_q),
    .item_o        (front_item)
  );

  tcvi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  tcvi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .cfg_i        (cfg_q),
    .res_pop_i    (pop),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign empty            = !res_valid;
  assign vel_x_o          = res.vel_x;
  assign vel_y_o          = res.vel_y;
  assign vel_z_o          = res.vel_z;
  assign speed_out_o      = res.speed_out;
  assign acc_x_filtered_o = res.acc_x_filtered;
  assign acc_y_filtered_o = res.acc_y_filtered;
  assign acc_z_filtered_o = res.acc_z_filtered;

endmodule
